>>> hdl/wsd_pkg.sv
// Package for the WebSocket frame deframer: parse steps, opcodes, result kinds,
// the result item struct and the default sizes.
// No dependencies.
`default_nettype none

package wsd_pkg;

  localparam int unsigned LENGTH_BITS_DEFAULT = 64;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  typedef enum logic [2:0] {
    ST_START = 3'd0,
    ST_LEN7  = 3'd1,
    ST_LEN16 = 3'd2,
    ST_LEN64 = 3'd3,
    ST_KEY   = 3'd4,
    ST_DATA  = 3'd5
  } step_t;

  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_PONG    = 2'd2;
  localparam logic [1:0] KIND_CLOSE   = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic       is_binary;
    logic       message_last;
  } result_t;

endpackage : wsd_pkg

`default_nettype wire

>>> hdl/wsd_front.sv
// Front part of the deframer: parses header, length and mask key of each frame
// and classifies every accepted item into zero or one result item.
// Depends on wsd_pkg.
`default_nettype none

module wsd_front #(
  parameter int unsigned LENGTH_BITS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [7:0]        in_byte,
  input  logic              chunk_end,
  output logic              res_valid,
  output wsd_pkg::result_t  res
);
  import wsd_pkg::*;

  step_t                   step, step_next;
  logic [7:0]              header_byte;
  logic                    masked;
  logic [LENGTH_BITS-1:0]  rem;
  logic                    ovf;
  logic [2:0]              hpos;
  logic [7:0]              mask_key [4];
  logic [1:0]              kpos;
  logic [1:0]              phase;
  logic                    close_done;
  logic                    drop;

  logic                    active;
  logic [6:0]              l7;
  logic [LENGTH_BITS+7:0]  ext;
  logic                    ext_hi_nz;
  logic                    ext_done;
  logic [LENGTH_BITS-1:0]  ext_len;
  logic [7:0]              v;
  logic [3:0]              op;
  logic                    is_data;
  logic                    data_last;
  logic                    fin;

  // Shared decode of the current item.
  always_comb begin
    active    = in_valid && !drop;
    l7        = in_byte[6:0];
    ext       = {rem, in_byte};
    ext_hi_nz = |ext[LENGTH_BITS+7:LENGTH_BITS];
    ext_done  = (step == ST_LEN16 && hpos == 3'd1) || (step == ST_LEN64 && hpos == 3'd7);
    ext_len   = (ovf || ext_hi_nz) ? {LENGTH_BITS{1'b1}} : ext[LENGTH_BITS-1:0];
    v         = masked ? (in_byte ^ mask_key[phase]) : in_byte;
    op        = header_byte[3:0];
    is_data   = (op == OP_TEXT) || (op == OP_BINARY);
    data_last = (rem == '0) || (rem == LENGTH_BITS'(1));
    fin = active && (
            (step == ST_LEN7 && l7 == 7'd0 && !in_byte[7]) ||
            (ext_done && !masked && ext_len == '0) ||
            (step == ST_KEY && kpos == 2'd3 && rem == '0) ||
            (step == ST_DATA && data_last));
  end

  // Next parse step.
  always_comb begin
    step_next = step;
    if (active) begin
      unique case (step)
        ST_START: step_next = ST_LEN7;
        ST_LEN7: begin
          if (l7 == LEN_CODE_16)      step_next = ST_LEN16;
          else if (l7 == LEN_CODE_64) step_next = ST_LEN64;
          else if (in_byte[7])        step_next = ST_KEY;
          else if (l7 == 7'd0)        step_next = ST_START;
          else                        step_next = ST_DATA;
        end
        ST_LEN16, ST_LEN64: begin
          if (ext_done) begin
            if (masked)               step_next = ST_KEY;
            else if (ext_len == '0)   step_next = ST_START;
            else                      step_next = ST_DATA;
          end
        end
        ST_KEY: begin
          if (kpos == 2'd3) step_next = (rem == '0) ? ST_START : ST_DATA;
        end
        ST_DATA: begin
          if (data_last) step_next = ST_START;
        end
        default: step_next = ST_START;
      endcase
    end
  end

  // Result item for the current item.
  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    if (fin) begin
      if (is_data) begin
        res_valid        = 1'b1;
        res.kind         = (step == ST_DATA) ? KIND_PAYLOAD : KIND_EMPTY;
        res.payload_byte = (step == ST_DATA) ? v : 8'd0;
        res.is_binary    = (op == OP_BINARY);
        res.message_last = 1'b1;
      end else if (op == OP_PING && !close_done) begin
        res_valid = 1'b1;
        res.kind  = KIND_PONG;
      end else if (op == OP_CLOSE && !close_done) begin
        res_valid = 1'b1;
        res.kind  = KIND_CLOSE;
      end
    end else if (active && step == ST_DATA && is_data) begin
      res_valid        = 1'b1;
      res.kind         = KIND_PAYLOAD;
      res.payload_byte = v;
      res.is_binary    = (op == OP_BINARY);
      res.message_last = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step        <= ST_START;
      header_byte <= '0;
      masked      <= 1'b0;
      rem         <= '0;
      ovf         <= 1'b0;
      hpos        <= '0;
      mask_key    <= '{default: '0};
      kpos        <= '0;
      phase       <= '0;
      close_done  <= 1'b0;
      drop        <= 1'b0;
    end else begin
      step <= step_next;
      if (in_valid && drop && chunk_end) drop <= 1'b0;
      if (active) begin
        case (step)
          ST_START: header_byte <= in_byte;
          ST_LEN7: begin
            masked <= in_byte[7];
            ovf    <= 1'b0;
            hpos   <= '0;
            kpos   <= '0;
            phase  <= '0;
            if (l7 == LEN_CODE_16 || l7 == LEN_CODE_64) rem <= '0;
            else                                        rem <= LENGTH_BITS'(l7);
          end
          ST_LEN16, ST_LEN64: begin
            if (ext_done) begin
              rem  <= ext_len;
              hpos <= '0;
            end else begin
              rem  <= ext[LENGTH_BITS-1:0];
              ovf  <= ovf | ext_hi_nz;
              hpos <= hpos + 3'd1;
            end
          end
          ST_KEY: begin
            mask_key[kpos] <= in_byte;
            kpos           <= kpos + 2'd1;
            phase          <= '0;
          end
          ST_DATA: begin
            phase <= phase + 2'd1;
            if (rem != '0) rem <= rem - LENGTH_BITS'(1);
          end
          default: ;
        endcase
        if (fin) begin
          rem   <= '0;
          hpos  <= '0;
          kpos  <= '0;
          phase <= '0;
          if (op == OP_CLOSE) begin
            close_done <= 1'b1;
            drop       <= !chunk_end;
          end
        end
      end
    end
  end

endmodule : wsd_front

`default_nettype wire

>>> hdl/wsd_queue.sv
// Back part of the deframer: a short first-in first-out queue of result items
// that holds them until the consumer pops them. Depends on wsd_pkg.
`default_nettype none

module wsd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  wsd_pkg::result_t  wr_data,
  input  logic              rd_en,
  output wsd_pkg::result_t  rd_data,
  output logic              full,
  output logic              empty
);
  import wsd_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  result_t       slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (do_rd) rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (do_wr && !do_rd)      count <= count + CW'(1);
      else if (do_rd && !do_wr) count <= count - CW'(1);
    end
  end

endmodule : wsd_queue

`default_nettype wire

>>> hdl/websocket_frame_deframer.sv
// WebSocket frame deframer, top level. One byte item is taken per cycle
// while full is low; an item's result enters the queue at the same edge and
// can be popped from the next cycle on.
// Input stalls (full high) only when QUEUE_DEPTH results wait unpopped.
// Reset is synchronous, active high, and leaves the parser at a frame start.
// Depends on wsd_pkg, wsd_front and wsd_queue.
`default_nettype none

module websocket_frame_deframer #(
  parameter int unsigned LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEFAULT,
  parameter int unsigned QUEUE_DEPTH = wsd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       chunk_end,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] out_kind,
  output logic [7:0] payload_byte,
  output logic       is_binary,
  output logic       message_last
);
  import wsd_pkg::*;

  // An item is accepted whenever the queue has room. Since each item makes
  // at most one result, room for one result is all the parser ever needs.
  logic    accept;
  logic    res_valid;
  result_t res;
  result_t head;

  assign accept = push && !full;

  // The parser walks header byte, length byte, extended length and mask key,
  // then unmasks payload bytes. Close handling and chunk dropping live there.
  wsd_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_byte   (in_byte),
    .chunk_end (chunk_end),
    .res_valid (res_valid),
    .res       (res)
  );

  // The queue decouples the parser from the consumer so that a stalled
  // consumer does not stop input until the queue fills.
  wsd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_valid),
    .wr_data (res),
    .rd_en   (pop),
    .rd_data (head),
    .full    (full),
    .empty   (empty)
  );

  assign out_kind     = head.kind;
  assign payload_byte = head.payload_byte;
  assign is_binary    = head.is_binary;
  assign message_last = head.message_last;

endmodule : websocket_frame_deframer

`default_nettype wire
